// File: hdl/iefilt_pkg.sv
`default_nettype none

package iefilt_pkg;

  // Frame layout, in bytes from the first byte of the Ethernet header.
  localparam int unsigned EthHdrBytes  = 14;
  localparam int unsigned MinFrameLen  = 34;
  localparam int unsigned IcmpHdrBytes = 8;
  localparam logic [16:0] OffIhl       = 17'd14;
  localparam logic [16:0] OffTotHi     = 17'd16;
  localparam logic [16:0] OffTotLo     = 17'd17;
  localparam logic [16:0] OffProto     = 17'd23;
  localparam logic [16:0] OffsetMax    = 17'h1FFFF;

  // Offsets inside the ICMP header.
  localparam logic [16:0] RelType   = 17'd0;
  localparam logic [16:0] RelIdHi   = 17'd4;
  localparam logic [16:0] RelIdLo   = 17'd5;
  localparam logic [16:0] RelHdrEnd = 17'd7;

  // Field codes.
  localparam logic [7:0] ProtoIcmp       = 8'd1;
  localparam logic [7:0] TypeEchoReply   = 8'd0;
  localparam logic [7:0] TypeEchoRequest = 8'd8;
  localparam logic [3:0] IhlMin          = 4'd5;

  // Register map.
  localparam logic [15:0] IdentReset = 16'hA387;
  localparam int unsigned AddrWidth  = 2;

  // One result word.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       kind;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/iefilt_parse.sv
`default_nettype none

module iefilt_parse (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_fire,
  input  wire logic [7:0]          data_byte,
  input  wire logic                frame_start,
  input  wire logic [15:0]         frame_len,
  input  wire logic [15:0]         match_ident,
  output logic                     emit,
  output iefilt_pkg::res_t         res
);

  logic [16:0] offset_r, offset_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [15:0] iptl_r, iptl_nxt;
  logic        kind_r, kind_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic        drop_r, drop_nxt;
  logic [15:0] left_r, left_nxt;

  // Values as seen by this word, after a frame start has cleared them.
  logic [16:0] off_e;
  logic [15:0] flen_e;
  logic [3:0]  hw_e;
  logic [15:0] iptl_e;
  logic        kind_e;
  logic [15:0] ident_e;
  logic        drop_e;
  logic [15:0] left_e;

  logic [6:0]  icmp_off;
  logic [16:0] rel;
  logic [15:0] need;
  logic [15:0] tot;
  logic [15:0] id_full;
  logic [15:0] hdr_need;

  always_comb begin
    if (frame_start) begin
      off_e   = '0;
      flen_e  = frame_len;
      hw_e    = '0;
      iptl_e  = '0;
      kind_e  = 1'b0;
      ident_e = '0;
      left_e  = '0;
      drop_e  = (frame_len < 16'(iefilt_pkg::MinFrameLen));
    end else begin
      off_e   = offset_r;
      flen_e  = flen_r;
      hw_e    = hw_r;
      iptl_e  = iptl_r;
      kind_e  = kind_r;
      ident_e = ident_r;
      left_e  = left_r;
      drop_e  = drop_r;
    end
  end

  // Header field decode and the accept decision.
  always_comb begin
    icmp_off   = 7'(iefilt_pkg::EthHdrBytes) + {1'b0, hw_e, 2'b00};
    rel        = off_e - {10'b0, icmp_off};
    need       = {10'b0, hw_e, 2'b00} + 16'(iefilt_pkg::IcmpHdrBytes);
    tot        = {iptl_e[15:8], data_byte};
    id_full    = {ident_e[15:8], data_byte};
    hdr_need   = 16'(iefilt_pkg::EthHdrBytes + iefilt_pkg::IcmpHdrBytes)
                 + {10'b0, data_byte[3:0], 2'b00};
    flen_nxt   = flen_e;
    hw_nxt     = hw_e;
    iptl_nxt   = iptl_e;
    kind_nxt   = kind_e;
    ident_nxt  = ident_e;
    left_nxt   = left_e;
    drop_nxt   = drop_e;
    emit       = 1'b0;
    res        = '0;
    res.kind   = kind_e;

    if (!drop_e) begin
      if (off_e == iefilt_pkg::OffIhl) begin
        hw_nxt = data_byte[3:0];
        if (data_byte[3:0] < iefilt_pkg::IhlMin || flen_e < hdr_need) begin
          drop_nxt = 1'b1;
        end
      end else if (off_e == iefilt_pkg::OffTotHi) begin
        iptl_nxt = {data_byte, 8'h00};
      end else if (off_e == iefilt_pkg::OffTotLo) begin
        iptl_nxt = tot;
        if (tot < {10'b0, hw_e, 2'b00}) begin
          drop_nxt = 1'b1;
        end
      end else if (off_e == iefilt_pkg::OffProto) begin
        if (data_byte != iefilt_pkg::ProtoIcmp) begin
          drop_nxt = 1'b1;
        end
      end else if (off_e > iefilt_pkg::OffProto && off_e >= {10'b0, icmp_off}) begin
        if (rel == iefilt_pkg::RelType) begin
          if (data_byte != iefilt_pkg::TypeEchoReply &&
              data_byte != iefilt_pkg::TypeEchoRequest) begin
            drop_nxt = 1'b1;
          end else begin
            kind_nxt = (data_byte == iefilt_pkg::TypeEchoRequest);
          end
        end else if (rel == iefilt_pkg::RelIdHi) begin
          ident_nxt = {data_byte, 8'h00};
        end else if (rel == iefilt_pkg::RelIdLo) begin
          ident_nxt = id_full;
          if (id_full != match_ident) begin
            drop_nxt = 1'b1;
          end
        end else if (rel == iefilt_pkg::RelHdrEnd) begin
          if (iptl_e < need ||
              {1'b0, flen_e} < 17'(iefilt_pkg::EthHdrBytes) + {1'b0, iptl_e}) begin
            drop_nxt = 1'b1;
          end else begin
            left_nxt = iptl_e - need;
            if (iptl_e == need) begin
              // Empty payload: one notice word without a byte.
              emit     = 1'b1;
              res.last = 1'b1;
              drop_nxt = 1'b1;
            end
          end
        end else if (rel > iefilt_pkg::RelHdrEnd && left_e != '0) begin
          left_nxt         = left_e - 16'd1;
          emit             = 1'b1;
          res.payload_byte = data_byte;
          res.has_byte     = 1'b1;
          res.last         = (left_e == 16'd1);
          if (left_e == 16'd1) begin
            drop_nxt = 1'b1;
          end
        end
      end
    end

    offset_nxt = (off_e < iefilt_pkg::OffsetMax) ? off_e + 17'd1 : off_e;
  end

  // Frame state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      flen_r   <= '0;
      hw_r     <= '0;
      iptl_r   <= '0;
      kind_r   <= 1'b0;
      ident_r  <= '0;
      drop_r   <= 1'b1;
      left_r   <= '0;
    end else if (in_fire) begin
      offset_r <= offset_nxt;
      flen_r   <= flen_nxt;
      hw_r     <= hw_nxt;
      iptl_r   <= iptl_nxt;
      kind_r   <= kind_nxt;
      ident_r  <= ident_nxt;
      drop_r   <= drop_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/icmp_echo_frame_filter.sv
// A result word is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one frame byte per cycle while in_stall is low; the parser state updates in a single pass.
// A two-entry output buffer lets input continue while one result waits; in_stall
// rises only when both entries are full.
// Synchronous active-low reset idles the parser until the next frame start,
// empties the output buffer and sets match_ident to 0xA387.
`default_nettype none

module icmp_echo_frame_filter (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Frame byte input.
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [7:0]                          in_data_byte,
  input  wire logic                                in_frame_start,
  input  wire logic [15:0]                         in_frame_len,
  // Payload output.
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [7:0]                               out_payload_byte,
  output logic                                     out_has_byte,
  output logic                                     out_kind,
  output logic                                     out_last,
  // Register port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [iefilt_pkg::AddrWidth-1:0]    paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  logic             in_fire;
  logic             out_fire;
  logic             emit;
  iefilt_pkg::res_t res;
  iefilt_pkg::res_t out_r;
  iefilt_pkg::res_t skid_r;
  logic             out_v_r;
  logic             skid_v_r;
  logic [15:0]      match_ident_r;

  // Register port: a single register, so every address selects it.
  assign pready = 1'b1;
  assign prdata = {16'h0000, match_ident_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_ident_r <= iefilt_pkg::IdentReset;
    end else if (psel && penable && pwrite && paddr == paddr) begin
      match_ident_r <= pwdata[15:0];
    end
  end

  // Handshakes.
  assign in_stall = skid_v_r;
  assign in_fire  = in_valid && !skid_v_r;
  assign out_fire = out_v_r && !out_stall;

  iefilt_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .frame_len   (in_frame_len),
    .match_ident (match_ident_r),
    .emit        (emit),
    .res         (res)
  );

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_fire || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= in_fire && emit;
      end
    end else if (in_fire && emit) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_v_r) begin
      out_r <= skid_v_r ? skid_r : res;
    end
    if (!skid_v_r) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_has_byte     = out_r.has_byte;
  assign out_kind         = out_r.kind;
  assign out_last         = out_r.last;

endmodule

`default_nettype wire
